// File: hw/rtl/fudw_pkg.sv
// Shared types, constants and the display address map of the framed UART display writer.
`default_nettype none

package fudw_pkg;

	localparam logic [7:0] START_RESET = 8'hA0;
	localparam logic [7:0] END_RESET   = 8'h0A;
	localparam logic [7:0] ACK_RESET   = 8'h0D;
	localparam logic [7:0] ADDR_BASE   = 8'hC0;
	localparam logic [7:0] ADDR_MASK   = 8'h0F;
	localparam int unsigned POS_W      = 4;
	localparam int unsigned APB_ADDR_W = 4;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_END   = 2'd1;
	localparam logic [1:0] REG_ACK   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RECV,
		ST_PAIR,
		ST_CMD,
		ST_ACK
	} state_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_ADDR,
		KIND_DATA,
		KIND_CMD,
		KIND_ACK
	} item_kind_t;

	typedef struct packed {
		logic       store;
		logic       first;
		logic       advance;
		item_kind_t load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_start;
		logic frame_full;
		logic frame_good;
		logic cmd_nonzero;
		logic pair_last;
		logic phase;
		logic out_free;
	} dp_status_t;

	function automatic logic [7:0] addr_map(input logic [POS_W-1:0] idx);
		logic [7:0] v;
		unique case (idx)
			4'd0:    v = 8'h00;
			4'd1:    v = 8'h01;
			4'd2:    v = 8'h02;
			4'd3:    v = 8'h03;
			4'd4:    v = 8'h04;
			4'd5:    v = 8'h05;
			4'd6:    v = 8'h06;
			4'd7:    v = 8'h08;
			4'd8:    v = 8'h0A;
			4'd9:    v = 8'h0C;
			4'd10:   v = 8'h0E;
			4'd11:   v = 8'h0F;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/framed_uart_to_display_writer_core.sv
// Top level: configuration registers, controller and datapath of the framed UART display writer.
// A good frame's closing byte moves the controller to ST_PAIR, which loads the first result.
// Throughput: one received byte per cycle while collecting a frame; a good frame then gives
// 2*DATA_SLOTS+1 or 2*DATA_SLOTS+2 results (25 or 26), one per cycle while m_tready holds.
// Input requests are not taken during a run; the output register alone paces it.
// Reset: arst_n clears state and counters and loads the markers 0xA0, 0x0A, 0x0D.
`default_nettype none

module framed_uart_to_display_writer_core #(
	parameter int unsigned FRAME_LEN  = 15,
	parameter int unsigned DATA_SLOTS = 12
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [7:0]                         s_tdata,   // [7:0] rx_byte
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [7:0]                         m_tdata,   // [7:0] out_byte
	output logic [1:0]                         m_tuser,   // [0] destination, [1] strobe_first
	output logic                               m_tlast,   // last_of_run
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [fudw_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire  [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import fudw_pkg::*;

	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;
	logic [7:0] ack_value_q;
	logic       cfg_wr;
	logic [1:0] reg_idx;
	logic       reg_hit;
	dp_cmd_t    cmd;
	dp_status_t status;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign reg_hit = (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_RESET;
			end_marker_q   <= END_RESET;
			ack_value_q    <= ACK_RESET;
		end else if (cfg_wr && reg_hit) begin
			unique case (reg_idx)
				REG_START: start_marker_q <= pwdata[7:0];
				REG_END:   end_marker_q   <= pwdata[7:0];
				REG_ACK:   ack_value_q    <= pwdata[7:0];
				default:   ack_value_q    <= ack_value_q;
			endcase
		end
	end

	always_comb begin
		prdata = 32'h0;
		if (reg_hit) begin
			unique case (reg_idx)
				REG_START: prdata = 32'(start_marker_q);
				REG_END:   prdata = 32'(end_marker_q);
				REG_ACK:   prdata = 32'(ack_value_q);
				default:   prdata = 32'h0;
			endcase
		end
	end

	fudw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fudw_datapath #(
		.FRAME_LEN  (FRAME_LEN),
		.DATA_SLOTS (DATA_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (s_tdata),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.ack_value    (ack_value_q),
		.cmd          (cmd),
		.status       (status),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

endmodule

`default_nettype wire

// File: hw/rtl/fudw_ctrl.sv
// Controller state machine: frame reception and sequencing of the output run.
`default_nettype none

module fudw_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  fudw_pkg::dp_status_t status,
	output fudw_pkg::dp_cmd_t    cmd
);
	import fudw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.store   = 1'b0;
		cmd.first   = 1'b0;
		cmd.advance = 1'b0;
		cmd.load    = KIND_NONE;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && status.is_start) begin
					cmd.store = 1'b1;
					cmd.first = 1'b1;
					state_d   = ST_RECV;
				end
			end
			ST_RECV: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.store = 1'b1;
					if (status.frame_full) begin
						state_d = status.frame_good ? ST_PAIR : ST_IDLE;
					end
				end
			end
			ST_PAIR: begin
				if (status.out_free) begin
					cmd.load    = status.phase ? KIND_DATA : KIND_ADDR;
					cmd.advance = 1'b1;
					if (status.pair_last) begin
						state_d = status.cmd_nonzero ? ST_CMD : ST_ACK;
					end
				end
			end
			ST_CMD: begin
				if (status.out_free) begin
					cmd.load = KIND_CMD;
					state_d  = ST_ACK;
				end
			end
			ST_ACK: begin
				if (status.out_free) begin
					cmd.load = KIND_ACK;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/fudw_datapath.sv
// Datapath: frame store, byte and slot counters, and the output register.
`default_nettype none

module fudw_datapath #(
	parameter int unsigned FRAME_LEN  = 15,
	parameter int unsigned DATA_SLOTS = 12
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [7:0]           rx_byte,
	input  wire  [7:0]           start_marker,
	input  wire  [7:0]           end_marker,
	input  wire  [7:0]           ack_value,
	input  fudw_pkg::dp_cmd_t    cmd,
	output fudw_pkg::dp_status_t status,
	input  wire                  m_tready,
	output logic                 m_tvalid,
	output logic [7:0]           m_tdata,
	output logic [1:0]           m_tuser,
	output logic                 m_tlast
);
	import fudw_pkg::*;

	localparam int unsigned CW  = $clog2(FRAME_LEN);
	localparam int unsigned SLW = (DATA_SLOTS > 1) ? $clog2(DATA_SLOTS) : 1;

	logic [7:0]     store_q [FRAME_LEN];
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  wr_idx;
	logic [SLW-1:0] slot_q;
	logic           phase_q;
	logic           out_valid_q;
	logic           out_dest_q;
	logic           out_strobe_q;
	logic           out_last_q;
	logic [7:0]     out_byte_q;
	logic [POS_W-1:0] data_pos;
	logic [7:0]     data_byte;
	logic [7:0]     addr_byte;
	logic [7:0]     cmd_byte;

	assign wr_idx = cmd.first ? '0 : count_q;

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_q[wr_idx] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			slot_q  <= '0;
			phase_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				count_q <= wr_idx + 1'b1;
			end
			if (cmd.first) begin
				slot_q  <= '0;
				phase_q <= 1'b0;
			end else if (cmd.advance) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	assign data_pos  = POS_W'(slot_q) + POS_W'(1);
	assign data_byte = (data_pos < POS_W'(FRAME_LEN)) ? store_q[data_pos[CW-1:0]] : 8'h00;
	assign addr_byte = ADDR_BASE | (addr_map(POS_W'(slot_q)) & ADDR_MASK);
	assign cmd_byte  = store_q[FRAME_LEN-2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load != KIND_NONE) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.load)
			KIND_ADDR: begin
				out_dest_q   <= 1'b0;
				out_strobe_q <= 1'b1;
				out_byte_q   <= addr_byte;
				out_last_q   <= 1'b0;
			end
			KIND_DATA: begin
				out_dest_q   <= 1'b0;
				out_strobe_q <= 1'b0;
				out_byte_q   <= data_byte;
				out_last_q   <= 1'b0;
			end
			KIND_CMD: begin
				out_dest_q   <= 1'b0;
				out_strobe_q <= 1'b1;
				out_byte_q   <= cmd_byte;
				out_last_q   <= 1'b0;
			end
			KIND_ACK: begin
				out_dest_q   <= 1'b1;
				out_strobe_q <= 1'b0;
				out_byte_q   <= ack_value;
				out_last_q   <= 1'b1;
			end
			default: begin
				out_dest_q   <= out_dest_q;
			end
		endcase
	end

	assign status.is_start    = (rx_byte == start_marker);
	assign status.frame_full  = (count_q == CW'(FRAME_LEN - 1));
	assign status.frame_good  = (rx_byte == end_marker) && (store_q[0] == start_marker);
	assign status.cmd_nonzero = (cmd_byte != 8'h00);
	assign status.pair_last   = phase_q && (slot_q == SLW'(DATA_SLOTS - 1));
	assign status.phase       = phase_q;
	assign status.out_free    = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_strobe_q, out_dest_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/fudw_checker.sv
// Port-level checker of the framed UART display writer and its bind.
`default_nettype none

module fudw_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tvalid,
	input wire       s_tready,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire [1:0] m_tuser,
	input wire       m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output request changed while stalled");

	a_host_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && !m_tuser[1])
		else $error("host byte is not the closing acknowledge");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown({m_tdata, m_tuser, m_tlast}))
		else $error("output request carries unknown bits");

	a_run_after_input: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("run started without an input request");

endmodule

bind framed_uart_to_display_writer_core fudw_checker u_fudw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
